>>> hw/rtl/qrv_pkg.sv
package qrv_pkg;

	localparam int QUAT_FRAC_BITS = 30;

	localparam int G_W  = 40;
	localparam int H_W  = 33;
	localparam int HH_W = 36;
	localparam int H3_W = 39;
	localparam int A_W  = 36;
	localparam int KA_W = 40;
	localparam int T_W  = 48;
	localparam int SUM_W = 50;

	localparam logic [60:0] ONE_Q60     = 61'(64'd1 << 60);
	localparam logic [60:0] SMALL_LIMIT = 61'((64'd1 << 60) / 64'd1000000000);
	localparam logic [31:0] VAR_MAX     = 32'hFFFF_FFFF;

	typedef struct packed {
		logic                   small_ang;
		logic signed [G_W-1:0]  g;
		logic [H_W-1:0]         h;
		logic [HH_W-1:0]        hh;
	} scal_res_t;

	typedef struct packed {
		logic        valid;
		logic        busy;
		logic [31:0] var_v;
		logic        sat;
		logic        small_ang;
	} lane_res_t;

	function automatic logic [31:0] atan_entry(input logic [4:0] i);
		logic [31:0] e;
		case (i)
			5'd0: e = 32'd843314857;
			5'd1: e = 32'd497837829;
			5'd2: e = 32'd263043837;
			5'd3: e = 32'd133525159;
			5'd4: e = 32'd67021687;
			5'd5: e = 32'd33543516;
			5'd6: e = 32'd16775851;
			5'd7: e = 32'd8388437;
			5'd8: e = 32'd4194283;
			5'd9: e = 32'd2097149;
			default: e = 32'd1 << (5'd30 - i);
		endcase
		return e;
	endfunction

	function automatic logic signed [31:0] series_coef(input logic [2:0] k);
		logic signed [31:0] c;
		case (k)
			3'd0: c = -32'sd357913941;
			3'd1: c = 32'sd35791394;
			3'd2: c = -32'sd1278264;
			3'd3: c = 32'sd23672;
			3'd4: c = -32'sd269;
			default: c = 32'sd2;
		endcase
		return c;
	endfunction

endpackage

>>> hw/rtl/qrv_scalar.sv
module qrv_scalar (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [30:0]          w,
	input  logic [60:0]          s2,
	output logic                 done,
	output qrv_pkg::scal_res_t   res
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_SQRT = 7'b0000010,
		S_CORD = 7'b0000100,
		S_DIV  = 7'b0001000,
		S_MUL  = 7'b0010000,
		S_POLY = 7'b0100000,
		S_G    = 7'b1000000
	} scal_st_t;

	scal_st_t st_q;
	logic [5:0]  cnt_q;
	logic        done_q;
	qrv_pkg::scal_res_t res_q;

	logic [60:0] v_q;
	logic [61:0] r_q;
	logic [60:0] bit_q;
	logic signed [34:0] x_q, y_q;
	logic signed [32:0] z_q;
	logic [30:0] s_q;
	logic [30:0] rem_q;
	logic [32:0] dq_q;
	logic [30:0] theta_q;
	logic [31:0] u_q;
	logic signed [31:0] acc_q;
	logic [qrv_pkg::H3_W-1:0] h3_q;

	logic [61:0] sq_sum, r_nx;
	logic        sq_ge;
	logic [4:0]  cd_i;
	logic signed [34:0] dx, dy;
	logic signed [32:0] at, z_nx;
	logic [30:0] theta_c;
	logic [31:0] rem_sh, rem_sub;
	logic        dv_ge;
	logic [61:0] u_prod;
	logic [65:0] hh_prod;
	logic [68:0] h3_prod;
	logic signed [64:0] poly_prod;
	logic signed [31:0] acc_nx;
	logic signed [71:0] g_prod;

	always_comb begin
		sq_sum = r_q + {1'b0, bit_q};
		sq_ge = {1'b0, v_q} >= sq_sum;
		r_nx = sq_ge ? ((r_q >> 1) + {1'b0, bit_q}) : (r_q >> 1);

		cd_i = cnt_q[4:0];
		dx = y_q >>> cd_i;
		dy = x_q >>> cd_i;
		at = $signed({1'b0, qrv_pkg::atan_entry(cd_i)});
		z_nx = (y_q > 35'sd0) ? (z_q + at) : (z_q - at);
		theta_c = z_nx[32] ? 31'd0 : z_nx[30:0];

		rem_sh = {rem_q, dq_q[32]};
		dv_ge = rem_sh >= {1'b0, s_q};
		rem_sub = rem_sh - {1'b0, s_q};

		u_prod = 62'(theta_q) * 62'(theta_q);
		hh_prod = 66'(res_q.h) * 66'(res_q.h);
		h3_prod = 69'(res_q.hh) * 69'(res_q.h);
		poly_prod = 65'(acc_q) * 65'($signed({1'b0, u_q}));
		acc_nx = qrv_pkg::series_coef(cnt_q[2:0]) + 32'(poly_prod >>> 30);
		g_prod = 72'(acc_q) * 72'($signed({1'b0, h3_q}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (start) begin
						if (s2 <= qrv_pkg::SMALL_LIMIT) begin
							done_q <= 1'b1;
						end else begin
							cnt_q <= '0;
							st_q <= S_SQRT;
						end
					end
				end
				S_SQRT: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd30) begin
						cnt_q <= '0;
						st_q <= S_CORD;
					end
				end
				S_CORD: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd29) begin
						cnt_q <= '0;
						st_q <= S_DIV;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd32) begin
						st_q <= S_MUL;
					end
				end
				S_MUL: begin
					cnt_q <= 6'd4;
					st_q <= S_POLY;
				end
				S_POLY: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd0) begin
						st_q <= S_G;
					end
				end
				S_G: begin
					done_q <= 1'b1;
					st_q <= S_IDLE;
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				if (start) begin
					res_q.small_ang <= s2 <= qrv_pkg::SMALL_LIMIT;
					v_q <= s2;
					r_q <= '0;
					bit_q <= 61'd1 << 60;
				end
			end
			S_SQRT: begin
				if (sq_ge) begin
					v_q <= v_q - sq_sum[60:0];
				end
				r_q <= r_nx;
				bit_q <= bit_q >> 2;
				x_q <= 35'($signed({1'b0, w}));
				y_q <= 35'($signed({1'b0, r_nx[30:0]}));
				s_q <= r_nx[30:0];
				z_q <= '0;
			end
			S_CORD: begin
				if (y_q > 35'sd0) begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
				end else begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
				end
				z_q <= z_nx;
				theta_q <= theta_c;
				rem_q <= theta_c >> 3;
				dq_q <= {theta_c[2:0], 30'd0};
			end
			S_DIV: begin
				rem_q <= dv_ge ? rem_sub[30:0] : rem_sh[30:0];
				dq_q <= {dq_q[31:0], dv_ge};
				res_q.h <= {dq_q[31:0], dv_ge};
			end
			S_MUL: begin
				u_q <= u_prod[61:30];
				res_q.hh <= hh_prod[65:30];
				acc_q <= qrv_pkg::series_coef(3'd5);
			end
			S_POLY: begin
				acc_q <= acc_nx;
				if (cnt_q == 6'd4) begin
					h3_q <= h3_prod[68:30];
				end
			end
			S_G: begin
				res_q.g <= qrv_pkg::G_W'(g_prod >>> 30);
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign res = res_q;

endmodule

>>> hw/rtl/qrv_lane.sv
module qrv_lane (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               small_ang,
	input  logic signed [31:0]                 q,
	input  logic signed [qrv_pkg::G_W-1:0]     g,
	input  logic [qrv_pkg::H_W-1:0]            h,
	input  logic [qrv_pkg::HH_W-1:0]           hh,
	input  logic [30:0]                        pww,
	input  logic signed [31:0]                 pwq,
	input  logic [30:0]                        pqq,
	output qrv_pkg::lane_res_t                 res
);

	logic v_s1, v_s2, v_s3, v_s4;

	logic signed [qrv_pkg::A_W-1:0] a_s1;
	logic [qrv_pkg::H_W-1:0]  h_s1;
	logic [qrv_pkg::HH_W-1:0] hh_s1, kh_s2;
	logic [30:0] pww_s1, pww_s2, pqq_s1, pqq_s2, pqq_s3;
	logic signed [31:0] pwq_s1, pwq_s2;
	logic small_s1, small_s2, small_s3, small_s4;

	logic [qrv_pkg::KA_W-1:0] ka_s2;
	logic signed [39:0] kab_s2;
	logic signed [qrv_pkg::T_W-1:0] t1_s3, t2_s3, t3_s3;
	logic [31:0] var_s4;
	logic        sat_s4;

	logic signed [71:0] qg;
	logic signed [71:0] aa;
	logic signed [69:0] ah;
	logic [70:0] p1;
	logic signed [71:0] p2;
	logic [66:0] p3;
	logic signed [qrv_pkg::SUM_W-1:0] sum, pre;

	always_comb begin
		qg = 72'(q) * 72'(g);
		aa = 72'(a_s1) * 72'(a_s1);
		ah = 70'(a_s1) * 70'($signed({1'b0, h_s1}));
		p1 = 71'(ka_s2) * 71'(pww_s2);
		p2 = 72'(kab_s2) * 72'(pwq_s2);
		p3 = 67'(kh_s2) * 67'(pqq_s2);
		sum = qrv_pkg::SUM_W'(t1_s3) + qrv_pkg::SUM_W'(t2_s3) + qrv_pkg::SUM_W'(t3_s3);
		pre = small_s3 ? $signed(qrv_pkg::SUM_W'({pqq_s3, 2'b00})) : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		a_s1 <= qrv_pkg::A_W'(qg >>> 29);
		h_s1 <= h;
		hh_s1 <= hh;
		pww_s1 <= pww;
		pwq_s1 <= pwq;
		pqq_s1 <= pqq;
		small_s1 <= small_ang;

		ka_s2 <= aa[71:32];
		kab_s2 <= 40'(ah >>> 30);
		kh_s2 <= hh_s1;
		pww_s2 <= pww_s1;
		pwq_s2 <= pwq_s1;
		pqq_s2 <= pqq_s1;
		small_s2 <= small_s1;

		t1_s3 <= $signed(qrv_pkg::T_W'(p1 >> 28));
		t2_s3 <= qrv_pkg::T_W'(p2 >>> 28);
		t3_s3 <= $signed(qrv_pkg::T_W'(p3 >> 28));
		pqq_s3 <= pqq_s2;
		small_s3 <= small_s2;

		small_s4 <= small_s3;
		if (pre < 0) begin
			var_s4 <= '0;
			sat_s4 <= 1'b1;
		end else if (pre > $signed(qrv_pkg::SUM_W'(qrv_pkg::VAR_MAX))) begin
			var_s4 <= qrv_pkg::VAR_MAX;
			sat_s4 <= 1'b1;
		end else begin
			var_s4 <= pre[31:0];
			sat_s4 <= 1'b0;
		end
	end

	always_comb begin
		res.valid = v_s4;
		res.busy = v_s1 | v_s2 | v_s3 | v_s4;
		res.var_v = var_s4;
		res.sat = sat_s4;
		res.small_ang = small_s4;
	end

endmodule

>>> hw/rtl/qrv_merge.sv
module qrv_merge (
	input  logic                clk,
	input  logic                arst_n,
	input  qrv_pkg::lane_res_t  lx,
	input  qrv_pkg::lane_res_t  ly,
	input  qrv_pkg::lane_res_t  lz,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [31:0]         var_x,
	output logic [31:0]         var_y,
	output logic [31:0]         var_z,
	output logic                small_angle,
	output logic                saturated
);

	logic        valid_q;
	logic [31:0] vx_q, vy_q, vz_q;
	logic        small_q, sat_q;

	// A new result only arrives while the output register is empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (lx.valid) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (lx.valid) begin
			vx_q <= lx.var_v;
			vy_q <= ly.var_v;
			vz_q <= lz.var_v;
			small_q <= lx.small_ang;
			sat_q <= lx.sat | ly.sat | lz.sat;
		end
	end

	assign out_valid = valid_q;
	assign var_x = vx_q;
	assign var_y = vy_q;
	assign var_z = vz_q;
	assign small_angle = small_q;
	assign saturated = sat_q;

endmodule

>>> hw/rtl/quat_rotvec_variance_top.sv
// On the rotation path, transactions pass one at a time through the shared scalar unit,
// which runs its square root, CORDIC and divider at one step per cycle.
// On the small-angle path the scalar unit skips those steps.
// An input register takes the next transaction while the current one is at work.
// Reset (arst_n low) empties every register stage and returns the sequencers to idle.
module quat_rotvec_variance_top #(
	parameter int QUAT_FRAC_BITS = qrv_pkg::QUAT_FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] quat_w,
	input  logic signed [31:0] quat_x,
	input  logic signed [31:0] quat_y,
	input  logic signed [31:0] quat_z,
	input  logic [30:0]        cov_ww,
	input  logic signed [31:0] cov_wx,
	input  logic [30:0]        cov_xx,
	input  logic signed [31:0] cov_wy,
	input  logic [30:0]        cov_yy,
	input  logic signed [31:0] cov_wz,
	input  logic [30:0]        cov_zz,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        var_x,
	output logic [31:0]        var_y,
	output logic [31:0]        var_z,
	output logic               small_angle,
	output logic               saturated
);

	localparam logic signed [31:0] QLIM = 32'sd1 <<< QUAT_FRAC_BITS;
	localparam int QSH = 30 - QUAT_FRAC_BITS;

	typedef enum logic [2:0] {
		C_IDLE = 3'b001,
		C_RUN  = 3'b010,
		C_WAIT = 3'b100
	} core_st_t;

	function automatic logic signed [31:0] q_cond(input logic signed [31:0] raw);
		logic signed [31:0] v;
		v = raw;
		if (v > QLIM) begin
			v = QLIM;
		end
		if (v < -QLIM) begin
			v = -QLIM;
		end
		return v <<< QSH;
	endfunction

	logic signed [31:0] cw, cx, cy, cz;
	logic               neg;
	logic signed [31:0] nw;

	logic        b_valid_q;
	logic [30:0] b_w_q;
	logic signed [31:0] b_x_q, b_y_q, b_z_q, b_wx_q, b_wy_q, b_wz_q;
	logic [30:0] b_ww_q, b_xx_q, b_yy_q, b_zz_q;

	core_st_t    st_q;
	logic        start_q;
	logic [30:0] c_w_q;
	logic [60:0] s2_q;
	logic signed [31:0] c_x_q, c_y_q, c_z_q, c_wx_q, c_wy_q, c_wz_q;
	logic [30:0] c_ww_q, c_xx_q, c_yy_q, c_zz_q;
	logic [61:0] ww_prod;

	logic                done;
	qrv_pkg::scal_res_t  sres;
	qrv_pkg::lane_res_t  lx, ly, lz;
	logic                launch;

	always_comb begin
		cw = q_cond(quat_w);
		cx = q_cond(quat_x);
		cy = q_cond(quat_y);
		cz = q_cond(quat_z);
		neg = cw[31];
		nw = neg ? -cw : cw;
		ww_prod = 62'(b_w_q) * 62'(b_w_q);
	end

	assign in_ready = !b_valid_q;
	assign launch = (st_q == C_WAIT) && !out_valid && !lx.busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_valid_q <= 1'b0;
			st_q <= C_IDLE;
			start_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (in_valid && in_ready) begin
				b_valid_q <= 1'b1;
			end else if (st_q == C_IDLE && b_valid_q) begin
				b_valid_q <= 1'b0;
			end
			case (st_q)
				C_IDLE: begin
					if (b_valid_q) begin
						start_q <= 1'b1;
						st_q <= C_RUN;
					end
				end
				C_RUN: begin
					if (done) begin
						st_q <= C_WAIT;
					end
				end
				C_WAIT: begin
					if (launch) begin
						st_q <= C_IDLE;
					end
				end
				default: begin
					st_q <= C_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			b_w_q <= nw[30:0];
			b_x_q <= neg ? -cx : cx;
			b_y_q <= neg ? -cy : cy;
			b_z_q <= neg ? -cz : cz;
			b_ww_q <= cov_ww;
			b_wx_q <= cov_wx;
			b_xx_q <= cov_xx;
			b_wy_q <= cov_wy;
			b_yy_q <= cov_yy;
			b_wz_q <= cov_wz;
			b_zz_q <= cov_zz;
		end
		if (st_q == C_IDLE && b_valid_q) begin
			c_w_q <= b_w_q;
			s2_q <= qrv_pkg::ONE_Q60 - ww_prod[60:0];
			c_x_q <= b_x_q;
			c_y_q <= b_y_q;
			c_z_q <= b_z_q;
			c_ww_q <= b_ww_q;
			c_wx_q <= b_wx_q;
			c_xx_q <= b_xx_q;
			c_wy_q <= b_wy_q;
			c_yy_q <= b_yy_q;
			c_wz_q <= b_wz_q;
			c_zz_q <= b_zz_q;
		end
	end

	qrv_scalar u_scalar (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.w      (c_w_q),
		.s2     (s2_q),
		.done   (done),
		.res    (sres)
	);

	qrv_lane u_lane_x (
		.clk (clk), .arst_n (arst_n), .in_valid (launch), .small_ang (sres.small_ang),
		.q (c_x_q), .g (sres.g), .h (sres.h), .hh (sres.hh),
		.pww (c_ww_q), .pwq (c_wx_q), .pqq (c_xx_q), .res (lx)
	);

	qrv_lane u_lane_y (
		.clk (clk), .arst_n (arst_n), .in_valid (launch), .small_ang (sres.small_ang),
		.q (c_y_q), .g (sres.g), .h (sres.h), .hh (sres.hh),
		.pww (c_ww_q), .pwq (c_wy_q), .pqq (c_yy_q), .res (ly)
	);

	qrv_lane u_lane_z (
		.clk (clk), .arst_n (arst_n), .in_valid (launch), .small_ang (sres.small_ang),
		.q (c_z_q), .g (sres.g), .h (sres.h), .hh (sres.hh),
		.pww (c_ww_q), .pwq (c_wz_q), .pqq (c_zz_q), .res (lz)
	);

	qrv_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.lx          (lx),
		.ly          (ly),
		.lz          (lz),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.var_x       (var_x),
		.var_y       (var_y),
		.var_z       (var_z),
		.small_angle (small_angle),
		.saturated   (saturated)
	);

endmodule
